// ===== rtl/core/brle_pkg.sv =====
package brle_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int LEN_W         = 7;
  localparam int SLOTS         = BITS_PER_BYTE + 1;
  localparam int FLUSH_SLOT    = BITS_PER_BYTE;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd127;
  localparam logic [LEN_W-1:0] LEN_ONE   = 7'd1;
  localparam logic [LEN_W-1:0] LEN_ZERO  = 7'd0;

  typedef struct packed {
    logic             cur_bit;
    logic [LEN_W-1:0] count;
    logic             started;
  } run_state_t;

  typedef struct packed {
    logic             value;
    logic [LEN_W-1:0] length;
    logic             flush;
  } code_t;

endpackage

// ===== rtl/core/brle_lane.sv =====
module brle_lane
  import brle_pkg::*;
(
  input  run_state_t       state_i,
  input  logic             bit_i,
  input  logic [LEN_W-1:0] limit_i,
  output run_state_t       state_o,
  output logic             emit_o,
  output code_t            code_o
);

  always_comb begin
    state_o      = state_i;
    emit_o       = 1'b0;
    code_o.value  = state_i.cur_bit;
    code_o.length = state_i.count;
    code_o.flush  = 1'b0;
    if (!state_i.started) begin
      state_o.started = 1'b1;
      state_o.cur_bit = bit_i;
      state_o.count   = LEN_ONE;
    end else if (bit_i != state_i.cur_bit) begin
      emit_o          = 1'b1;
      state_o.cur_bit = bit_i;
      state_o.count   = LEN_ONE;
    end else if (state_i.count >= limit_i) begin
      emit_o        = 1'b1;
      state_o.count = LEN_ONE;
    end else begin
      state_o.count = state_i.count + LEN_ONE;
    end
  end

endmodule

// ===== rtl/core/brle_merge.sv =====
module brle_merge
  import brle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  logic [SLOTS-1:0]       slot_vld_i,
  input  code_t [SLOTS-1:0]      slot_code_i,
  output logic                   can_load_o,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output code_t                  code_o,
  output logic                   last_o
);

  logic [SLOTS-1:0]  pend_r, pend_nxt;
  code_t [SLOTS-1:0] codes_r;
  logic [SLOTS-1:0]  pick;
  logic              xfer;

  assign pick       = pend_r & (~pend_r + {{(SLOTS-1){1'b0}}, 1'b1});
  assign out_tvalid = |pend_r;
  assign last_o     = (pend_r == pick) && out_tvalid;
  assign xfer       = out_tvalid && out_tready;
  assign can_load_o = !out_tvalid || (last_o && out_tready);

  always_comb begin
    code_o = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (pick[k]) begin
        code_o = code_o | codes_r[k];
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (load_i) begin
      pend_nxt = slot_vld_i;
    end else if (xfer) begin
      pend_nxt = pend_r & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      codes_r <= slot_code_i;
    end
  end

`ifndef SYNTH
  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> can_load_o)
    else $error("batch loaded while codes still pending");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !load_i && !xfer |=> $stable(pend_r))
    else $error("pending mask changed without transfer or load");

  a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !load_i |=> $countones(pend_r) == $countones($past(pend_r)) - 1)
    else $error("transfer did not retire exactly one code");
`endif

endmodule

// ===== rtl/core/bit_run_length_encoder_core.sv =====
// Channel | Direction | Transfer when            | Payload
// in_     | slave     | in_tvalid & in_tready    | tdata: data_byte; tlast: end_of_stream
// out_    | master    | out_tvalid & out_tready  | tdata: value, length, code; tlast, tuser
// cfg_    | slave     | cfg_valid & cfg_ready    | cfg_data: max_run_length
// A byte causes N codes (0 to 9), sent one code per cycle while out_tready is high;
// eight bit lanes resolve a whole byte combinationally.
// The next byte is taken in the cycle its predecessor's last code transfers.
// Synchronous active-low reset clears run state, pending codes, limit to 127.
// Output stalls hold the code; input stalls while codes are pending.
module bit_run_length_encoder_core
  import brle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] run_value, [7:1] run_length, [15:8] run_code
  output logic        out_tlast,  // last_result
  output logic        out_tuser,  // stream_flush
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // max_run_length
);

  logic [LEN_W-1:0]  max_len_r;
  logic [LEN_W-1:0]  limit;
  run_state_t        state_r, state_nxt;
  run_state_t        chain [BITS_PER_BYTE+1];
  logic [SLOTS-1:0]  slot_vld;
  code_t [SLOTS-1:0] slot_code;
  logic              accept;
  code_t             code_out;

  assign cfg_ready = 1'b1;
  assign limit     = (max_len_r == LEN_ZERO) ? LEN_ONE : max_len_r;
  assign accept    = in_tvalid && in_tready;
  assign chain[0]  = state_r;

  for (genvar k = 0; k < BITS_PER_BYTE; k++) begin : g_lane
    brle_lane u_lane (
      .state_i (chain[k]),
      .bit_i   (in_tdata[BITS_PER_BYTE-1-k]),
      .limit_i (limit),
      .state_o (chain[k+1]),
      .emit_o  (slot_vld[k]),
      .code_o  (slot_code[k])
    );
  end

  assign slot_vld[FLUSH_SLOT]  = in_tlast;
  assign slot_code[FLUSH_SLOT] = {chain[BITS_PER_BYTE].cur_bit,
                                  chain[BITS_PER_BYTE].count, 1'b1};
  assign state_nxt             = in_tlast ? '0 : chain[BITS_PER_BYTE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      max_len_r <= LEN_RESET;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_data;
      end
    end
  end

  brle_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (accept),
    .slot_vld_i  (slot_vld),
    .slot_code_i (slot_code),
    .can_load_o  (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .code_o      (code_out),
    .last_o      (out_tlast)
  );

  assign out_tdata = {code_out.value, code_out.length, code_out.length, code_out.value};
  assign out_tuser = code_out.flush;

endmodule

// ===== tb/sv/tb_bit_run_length_encoder_core.sv =====
module tb_bit_run_length_encoder_core;
  import brle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 28;

  typedef struct {
    bit             value;
    bit [LEN_W-1:0] length;
    bit             last;
    bit             flush;
  } run_code_t;

  class rle_scoreboard;
    run_code_t      expected_codes[$];
    bit             cur_bit;
    bit [LEN_W-1:0] run_len;
    bit             in_run;
    bit [LEN_W-1:0] max_len;
    int             errors;
    int             bytes_seen;
    int             codes_seen;
    int             flushes_seen;
    int             limit_writes;

    function new();
      max_len = LEN_RESET;
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_limit(bit [LEN_W-1:0] v);
      max_len = v;
      limit_writes++;
    endfunction

    function void push_code(bit v, bit [LEN_W-1:0] len, bit fl);
      run_code_t c;
      c.value  = v;
      c.length = len;
      c.last   = 1'b0;
      c.flush  = fl;
      expected_codes.push_back(c);
    endfunction

    // walk the byte MSB first, queue codes, mark the last one of this byte
    function void note_byte(bit [7:0] b, bit eos);
      bit [LEN_W-1:0] lim;
      int             first;
      bit             bv;
      run_code_t      tail;
      lim   = (max_len == LEN_ZERO) ? LEN_ONE : max_len;
      first = expected_codes.size();
      bytes_seen++;
      for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
        bv = b[i];
        if (!in_run) begin
          in_run  = 1'b1;
          cur_bit = bv;
          run_len = LEN_ONE;
        end else if (bv != cur_bit) begin
          push_code(cur_bit, run_len, 1'b0);
          cur_bit = bv;
          run_len = LEN_ONE;
        end else if (run_len >= lim) begin
          push_code(cur_bit, run_len, 1'b0);
          run_len = LEN_ONE;
        end else begin
          run_len = run_len + 1'b1;
        end
      end
      if (eos) begin
        if (in_run) push_code(cur_bit, run_len, 1'b1);
        cur_bit = 1'b0;
        run_len = LEN_ZERO;
        in_run  = 1'b0;
      end
      if (expected_codes.size() > first) begin
        tail = expected_codes.pop_back();
        tail.last = 1'b1;
        expected_codes.push_back(tail);
      end
    endfunction

    function void check_code(logic [15:0] d, logic lst, logic usr);
      run_code_t e;
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected code tdata=%h tlast=%b tuser=%b", d, lst, usr));
        return;
      end
      e = expected_codes.pop_front();
      codes_seen++;
      if (e.flush) flushes_seen++;
      if (d[0] !== e.value)
        report_mismatch($sformatf("run_value %b, want %b", d[0], e.value));
      if (d[7:1] !== e.length)
        report_mismatch($sformatf("run_length %0d, want %0d", d[7:1], e.length));
      if (d[15:8] !== {e.value, e.length})
        report_mismatch($sformatf("run_code %h, want %h", d[15:8], {e.value, e.length}));
      if (lst !== e.last)
        report_mismatch($sformatf("last_result %b, want %b", lst, e.last));
      if (usr !== e.flush)
        report_mismatch($sformatf("stream_flush %b, want %b", usr, e.flush));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // end_of_stream
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [0] run_value, [7:1] run_length, [15:8] run_code
  logic        out_tlast;  // last_result
  logic        out_tuser;  // stream_flush
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;   // max_run_length

  rle_scoreboard sb;
  bit            calm;
  int            idle_cycles;

  bit_run_length_encoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if (out_tvalid && out_tready) sb.check_code(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // call at a falling edge; returns at a falling edge with tvalid still high
  task automatic send_byte(bit [7:0] b, bit eos);
    if (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while (!calm && $urandom_range(99) < 32);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(bit [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_stream();
    int       len;
    int       pat;
    bit [7:0] b;
    bit [7:0] fill;
    pat  = $urandom_range(0, 3);
    len  = (pat == 0) ? $urandom_range(1, 20) : $urandom_range(1, 10);
    fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    for (int j = 0; j < len; j++) begin
      case (pat)
        0: b = fill;
        1: b = 8'($urandom_range(0, 255));
        2: b = j[0] ? 8'hAA : 8'h55;
        default: begin
          b = 8'hFF >> $urandom_range(0, 8);
          if (fill[0]) b = ~b;
        end
      endcase
      send_byte(b, j == len - 1);
    end
  endtask

  initial begin
    bit [6:0] limits[8];
    int       sent;
    int       base;
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = 7'd0;
    calm        = 1'b0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first bit opens a run, transitions, flush on end of stream
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h80, 1'b1);
    // 128 ones: cut at 127, then a flush of one
    for (int i = 0; i < 16; i++) send_byte(8'hFF, i == 15);
    // open a 16-bit run, then lower the limit below it
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    write_limit(7'd5);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b1);
    // zero limit behaves as one
    wait_idle();
    write_limit(7'd0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hC3, 1'b1);

    limits = '{7'd1, 7'd127, 7'd2, 7'd0, 7'd64, 7'd0, 7'd126, 7'd3};
    limits[5] = 7'($urandom_range(1, 127));
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_limit(limits[p]);
      calm = (p == 4);
      base = sb.bytes_seen;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          send_stream();
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        sent = sb.bytes_seen - base;
      end
    end
    calm = 1'b0;
    wait_idle();
    repeat (10) @(negedge clk);

    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d codes never arrived", sb.pending()));
    $display("Run covered %0d input bytes and %0d run codes, %0d of them end-of-stream flushes,",
             sb.bytes_seen, sb.codes_seen, sb.flushes_seen);
    $display("across %0d run-limit settings including 0, 1 and 127", sb.limit_writes + 1);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/brle_pkg.sv
rtl/core/brle_lane.sv
rtl/core/brle_merge.sv
rtl/core/bit_run_length_encoder_core.sv
tb/sv/tb_bit_run_length_encoder_core.sv
